### design/ldmc_pkg.sv
package ldmc_pkg;

    localparam int PAYLOAD_MAX = 5;

    // result status codes
    localparam logic [1:0] ST_DECODED   = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    // configuration register indexes
    localparam logic CFG_V11     = 1'b0;
    localparam logic CFG_CLASS_B = 1'b1;

    // command tags
    localparam logic [7:0] TAG_LINK_CHECK     = 8'd2;
    localparam logic [7:0] TAG_LINK_ADR       = 8'd3;
    localparam logic [7:0] TAG_DUTY_CYCLE     = 8'd4;
    localparam logic [7:0] TAG_RX_PARAM       = 8'd5;
    localparam logic [7:0] TAG_DEV_STATUS     = 8'd6;
    localparam logic [7:0] TAG_NEW_CHANNEL    = 8'd7;
    localparam logic [7:0] TAG_RX_TIMING      = 8'd8;
    localparam logic [7:0] TAG_TX_PARAM       = 8'd9;
    localparam logic [7:0] TAG_DL_CHANNEL     = 8'd10;
    localparam logic [7:0] TAG_RESET_CONF     = 8'd11;
    localparam logic [7:0] TAG_ADR_PARAM      = 8'd12;
    localparam logic [7:0] TAG_DEVICE_TIME    = 8'd13;
    localparam logic [7:0] TAG_FORCE_REJOIN   = 8'd14;
    localparam logic [7:0] TAG_REJOIN_PARAM   = 8'd15;
    localparam logic [7:0] TAG_PING_SLOT_INFO = 8'd16;
    localparam logic [7:0] TAG_PING_SLOT_CH   = 8'd17;
    localparam logic [7:0] TAG_BEACON_TIMING  = 8'd18;
    localparam logic [7:0] TAG_BEACON_FREQ    = 8'd19;

    localparam logic [6:0] FREQ_SCALE = 7'd100;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  cmd_tag;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [15:0] word_field;
        logic [3:0]  nibble_high;
        logic [3:0]  nibble_low;
        logic [2:0]  tri_a;
        logic [2:0]  tri_b;
        logic [2:0]  tri_c;
        logic [30:0] freq_hz;
        logic [31:0] time_seconds;
    } t_result;

    typedef struct packed {
        logic       known;
        logic [2:0] len;
    } t_len;

    function automatic t_len f_payload_len(input logic [7:0] tag, input logic v11,
                                           input logic class_b);
        t_len r;
        r = '{known: 1'b1, len: 3'd0};
        unique case (tag)
            TAG_LINK_CHECK:     r.len = 3'd2;
            TAG_LINK_ADR:       r.len = 3'd4;
            TAG_DUTY_CYCLE:     r.len = 3'd1;
            TAG_RX_PARAM:       r.len = 3'd4;
            TAG_DEV_STATUS:     r.len = 3'd0;
            TAG_NEW_CHANNEL:    r.len = 3'd5;
            TAG_RX_TIMING:      r.len = 3'd1;
            TAG_TX_PARAM:       r.len = 3'd1;
            TAG_DL_CHANNEL:     r.len = 3'd4;
            TAG_DEVICE_TIME:    r.len = 3'd5;
            TAG_RESET_CONF,
            TAG_ADR_PARAM,
            TAG_REJOIN_PARAM:   begin r.known = v11;     r.len = 3'd1; end
            TAG_FORCE_REJOIN:   begin r.known = v11;     r.len = 3'd2; end
            TAG_PING_SLOT_INFO: begin r.known = class_b; r.len = 3'd0; end
            TAG_PING_SLOT_CH:   begin r.known = class_b; r.len = 3'd4; end
            TAG_BEACON_TIMING,
            TAG_BEACON_FREQ:    begin r.known = class_b; r.len = 3'd3; end
            default:            r.known = 1'b0;
        endcase
        return r;
    endfunction

    // 24-bit little-endian frequency field times 100, fits in 31 bits
    function automatic logic [30:0] f_freq(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2);
        logic [30:0] v;
        v = {7'd0, b2, b1, b0};
        return v * {24'd0, FREQ_SCALE};
    endfunction

endpackage

### design/lorawan_downlink_mac_command_parser.sv
// Downlink MAC command parser. Takes one command byte per cycle (i_in_valid/o_in_stall),
// tracks the pending tag and its payload bytes, and on the last byte of a command, on an
// unknown or disabled tag, or on a frame that ends mid-command, loads one decoded record
// into the output register, visible in the cycle after the byte's transfer. The decode
// and the frequency scaling (24 x 7 bit multiply) sit in one combinational stage between
// the parser state and the output register, so a byte is taken every cycle; input stalls
// only while the output register holds a record that the consumer is stalling. Register
// writes are always ready and apply from the next tag byte.
module lorawan_downlink_mac_command_parser
    import ldmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_cmd_tag,
    output logic [7:0]  o_byte_a,
    output logic [7:0]  o_byte_b,
    output logic [15:0] o_word_field,
    output logic [3:0]  o_nibble_high,
    output logic [3:0]  o_nibble_low,
    output logic [2:0]  o_tri_a,
    output logic [2:0]  o_tri_b,
    output logic [2:0]  o_tri_c,
    output logic [30:0] o_freq_hz,
    output logic [31:0] o_time_seconds
);

    logic        r_en_v11;
    logic        r_en_class_b;
    logic [7:0]  r_active_tag;
    logic [2:0]  r_bytes_left;
    logic [2:0]  r_count;
    logic        r_discard;
    logic [7:0]  r_payload [PAYLOAD_MAX];
    logic        r_out_valid;
    t_result     r_out;

    logic [7:0]  n_active_tag;
    logic [2:0]  n_bytes_left;
    logic [2:0]  n_count;
    logic        n_discard;
    logic        n_has_res;
    t_result     n_res;

    logic        w_accept;
    logic        w_out_free;
    logic        w_store_wr;
    t_len        w_len;
    t_result     w_dec;
    logic [7:0]  w_dec_tag;
    logic [7:0]  w_p [PAYLOAD_MAX];
    logic [15:0] w_w14;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign w_out_free  = ~r_out_valid | ~i_out_stall;
    assign w_store_wr  = w_accept & ~r_discard & (r_bytes_left != 3'd0)
                         & (r_count < 3'(PAYLOAD_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_v11     <= 1'b0;
            r_en_class_b <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_V11:     r_en_v11     <= i_cfg_data;
                CFG_CLASS_B: r_en_class_b <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // payload bytes of the current command; the incoming byte stands in at r_count
    always_comb begin
        for (int k = 0; k < PAYLOAD_MAX; k++) begin
            w_p[k] = (r_count == 3'(k)) ? i_rx_byte : r_payload[k];
        end
    end

    assign w_len     = f_payload_len(i_rx_byte, r_en_v11, r_en_class_b);
    assign w_dec_tag = (r_bytes_left == 3'd0) ? i_rx_byte : r_active_tag;
    assign w_w14     = {w_p[1], w_p[0]};

    always_comb begin
        w_dec         = '0;
        w_dec.status  = ST_DECODED;
        w_dec.cmd_tag = w_dec_tag;
        unique case (w_dec_tag)
            TAG_LINK_CHECK: begin
                w_dec.byte_a = w_p[0];
                w_dec.byte_b = w_p[1];
            end
            TAG_LINK_ADR: begin
                w_dec.nibble_high = w_p[0][7:4];
                w_dec.nibble_low  = w_p[0][3:0];
                w_dec.word_field  = {w_p[2], w_p[1]};
                w_dec.tri_a       = w_p[3][6:4];
                w_dec.byte_b      = {4'd0, w_p[3][3:0]};
            end
            TAG_DUTY_CYCLE, TAG_RX_TIMING, TAG_RESET_CONF: begin
                w_dec.nibble_low = w_p[0][3:0];
            end
            TAG_RX_PARAM: begin
                w_dec.tri_a      = w_p[0][6:4];
                w_dec.nibble_low = w_p[0][3:0];
                w_dec.freq_hz    = f_freq(w_p[1], w_p[2], w_p[3]);
            end
            TAG_NEW_CHANNEL: begin
                w_dec.byte_a      = w_p[0];
                w_dec.freq_hz     = f_freq(w_p[1], w_p[2], w_p[3]);
                w_dec.nibble_high = w_p[4][7:4];
                w_dec.nibble_low  = w_p[4][3:0];
            end
            TAG_TX_PARAM: begin
                w_dec.byte_a = {2'd0, w_p[0][5:0]};
            end
            TAG_DL_CHANNEL: begin
                w_dec.byte_a  = w_p[0];
                w_dec.freq_hz = f_freq(w_p[1], w_p[2], w_p[3]);
            end
            TAG_DEVICE_TIME: begin
                w_dec.time_seconds = {w_p[3], w_p[2], w_p[1], w_p[0]};
                w_dec.byte_a       = w_p[4];
            end
            TAG_ADR_PARAM, TAG_REJOIN_PARAM: begin
                w_dec.nibble_high = w_p[0][7:4];
                w_dec.nibble_low  = w_p[0][3:0];
            end
            TAG_FORCE_REJOIN: begin
                w_dec.tri_a      = w_w14[12:10];
                w_dec.tri_b      = w_w14[9:7];
                w_dec.tri_c      = w_w14[6:4];
                w_dec.nibble_low = w_w14[3:0];
            end
            TAG_PING_SLOT_CH: begin
                w_dec.freq_hz    = f_freq(w_p[0], w_p[1], w_p[2]);
                w_dec.nibble_low = w_p[3][3:0];
            end
            TAG_BEACON_TIMING: begin
                w_dec.word_field = {w_p[1], w_p[0]};
                w_dec.byte_a     = w_p[2];
            end
            TAG_BEACON_FREQ: begin
                w_dec.freq_hz = f_freq(w_p[0], w_p[1], w_p[2]);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_active_tag = r_active_tag;
        n_bytes_left = r_bytes_left;
        n_count      = r_count;
        n_discard    = r_discard;
        n_has_res    = 1'b0;
        n_res        = w_dec;

        if (r_discard) begin
            // rest of the frame is dropped
        end else if (r_bytes_left == 3'd0) begin
            if (!w_len.known) begin
                n_has_res     = 1'b1;
                n_res         = '0;
                n_res.status  = ST_UNKNOWN;
                n_res.cmd_tag = i_rx_byte;
                n_discard     = 1'b1;
            end else if (w_len.len == 3'd0) begin
                n_has_res = 1'b1;
            end else begin
                n_active_tag = i_rx_byte;
                n_bytes_left = w_len.len;
                n_count      = 3'd0;
            end
        end else begin
            n_count      = r_count + 3'd1;
            n_bytes_left = r_bytes_left - 3'd1;
            if (r_bytes_left == 3'd1) begin
                n_has_res    = 1'b1;
                n_active_tag = 8'd0;
                n_count      = 3'd0;
            end
        end

        if (i_frame_end) begin
            if (!n_has_res && n_bytes_left != 3'd0) begin
                n_has_res     = 1'b1;
                n_res         = '0;
                n_res.status  = ST_TRUNCATED;
                n_res.cmd_tag = n_active_tag;
            end
            n_active_tag = 8'd0;
            n_bytes_left = 3'd0;
            n_count      = 3'd0;
            n_discard    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_tag <= 8'd0;
            r_bytes_left <= 3'd0;
            r_count      <= 3'd0;
            r_discard    <= 1'b0;
        end else if (w_accept) begin
            r_active_tag <= n_active_tag;
            r_bytes_left <= n_bytes_left;
            r_count      <= n_count;
            r_discard    <= n_discard;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_wr) begin
            r_payload[r_count] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_accept & n_has_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_accept && n_has_res) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_cmd_tag      = r_out.cmd_tag;
    assign o_byte_a       = r_out.byte_a;
    assign o_byte_b       = r_out.byte_b;
    assign o_word_field   = r_out.word_field;
    assign o_nibble_high  = r_out.nibble_high;
    assign o_nibble_low   = r_out.nibble_low;
    assign o_tri_a        = r_out.tri_a;
    assign o_tri_b        = r_out.tri_b;
    assign o_tri_c        = r_out.tri_c;
    assign o_freq_hz      = r_out.freq_hz;
    assign o_time_seconds = r_out.time_seconds;

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count + r_bytes_left <= 3'(PAYLOAD_MAX))
        else $error("payload count plus bytes left exceeds store depth");

    a_discard_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discard |-> (r_bytes_left == 3'd0))
        else $error("discarding while a command is pending");

    a_frame_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_frame_end) |=> (r_bytes_left == 3'd0 && !r_discard))
        else $error("frame end did not return parser to tag wait");

    a_discard_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_discard && !i_frame_end) |=> !o_out_valid)
        else $error("result produced for a discarded byte");

endmodule

### tb/mac_cmd_checker.sv
module mac_cmd_checker
    import ldmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_end,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_result    i_result,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        v11_en;
    logic        class_b_en;
    logic [7:0]  cur_tag;
    logic [2:0]  remaining;
    logic [7:0]  payload [PAYLOAD_MAX];
    int          stored;
    logic        skip_frame;
    t_result     decoded_q[$];
    t_result     oldest;

    // payload length of an accepted tag, -1 for unknown or disabled tags
    function automatic int cmd_len(input logic [7:0] tag);
        case (tag)
            TAG_LINK_CHECK:     return 2;
            TAG_LINK_ADR:       return 4;
            TAG_DUTY_CYCLE:     return 1;
            TAG_RX_PARAM:       return 4;
            TAG_DEV_STATUS:     return 0;
            TAG_NEW_CHANNEL:    return 5;
            TAG_RX_TIMING:      return 1;
            TAG_TX_PARAM:       return 1;
            TAG_DL_CHANNEL:     return 4;
            TAG_DEVICE_TIME:    return 5;
            TAG_RESET_CONF,
            TAG_ADR_PARAM,
            TAG_REJOIN_PARAM:   return v11_en ? 1 : -1;
            TAG_FORCE_REJOIN:   return v11_en ? 2 : -1;
            TAG_PING_SLOT_INFO: return class_b_en ? 0 : -1;
            TAG_PING_SLOT_CH:   return class_b_en ? 4 : -1;
            TAG_BEACON_TIMING,
            TAG_BEACON_FREQ:    return class_b_en ? 3 : -1;
            default:            return -1;
        endcase
    endfunction

    function automatic logic [30:0] scaled_freq(input logic [7:0] lo, input logic [7:0] mid,
                                                input logic [7:0] hi);
        logic [31:0] raw;
        raw = {8'd0, hi, mid, lo};
        raw = raw * 32'd100;
        return raw[30:0];
    endfunction

    function automatic t_result decode_command(input logic [7:0] tag);
        t_result     r;
        logic [15:0] w;
        r = '0;
        r.status = ST_DECODED;
        r.cmd_tag = tag;
        case (tag)
            TAG_LINK_CHECK: begin
                r.byte_a = payload[0];
                r.byte_b = payload[1];
            end
            TAG_LINK_ADR: begin
                r.nibble_high = payload[0][7:4];
                r.nibble_low = payload[0][3:0];
                r.word_field = {payload[2], payload[1]};
                r.tri_a = payload[3][6:4];
                r.byte_b = {4'd0, payload[3][3:0]};
            end
            TAG_DUTY_CYCLE, TAG_RX_TIMING, TAG_RESET_CONF: begin
                r.nibble_low = payload[0][3:0];
            end
            TAG_RX_PARAM: begin
                r.tri_a = payload[0][6:4];
                r.nibble_low = payload[0][3:0];
                r.freq_hz = scaled_freq(payload[1], payload[2], payload[3]);
            end
            TAG_NEW_CHANNEL: begin
                r.byte_a = payload[0];
                r.freq_hz = scaled_freq(payload[1], payload[2], payload[3]);
                r.nibble_high = payload[4][7:4];
                r.nibble_low = payload[4][3:0];
            end
            TAG_TX_PARAM: begin
                r.byte_a = {2'd0, payload[0][5:0]};
            end
            TAG_DL_CHANNEL: begin
                r.byte_a = payload[0];
                r.freq_hz = scaled_freq(payload[1], payload[2], payload[3]);
            end
            TAG_DEVICE_TIME: begin
                r.time_seconds = {payload[3], payload[2], payload[1], payload[0]};
                r.byte_a = payload[4];
            end
            TAG_ADR_PARAM, TAG_REJOIN_PARAM: begin
                r.nibble_high = payload[0][7:4];
                r.nibble_low = payload[0][3:0];
            end
            TAG_FORCE_REJOIN: begin
                w = {payload[1], payload[0]};
                r.tri_a = w[12:10];
                r.tri_b = w[9:7];
                r.tri_c = w[6:4];
                r.nibble_low = w[3:0];
            end
            TAG_PING_SLOT_CH: begin
                r.freq_hz = scaled_freq(payload[0], payload[1], payload[2]);
                r.nibble_low = payload[3][3:0];
            end
            TAG_BEACON_TIMING: begin
                r.word_field = {payload[1], payload[0]};
                r.byte_a = payload[2];
            end
            TAG_BEACON_FREQ: begin
                r.freq_hz = scaled_freq(payload[0], payload[1], payload[2]);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic fe);
        t_result r;
        logic    produced;
        int      len;
        produced = 1'b0;
        r = '0;
        if (!skip_frame) begin
            if (remaining == 3'd0) begin
                len = cmd_len(b);
                if (len < 0) begin
                    r.status = ST_UNKNOWN;
                    r.cmd_tag = b;
                    produced = 1'b1;
                    skip_frame = 1'b1;
                end else if (len == 0) begin
                    r = decode_command(b);
                    produced = 1'b1;
                end else begin
                    cur_tag = b;
                    remaining = len[2:0];
                    stored = 0;
                end
            end else begin
                if (stored < PAYLOAD_MAX) begin
                    payload[stored] = b;
                end
                stored++;
                remaining--;
                if (remaining == 3'd0) begin
                    r = decode_command(cur_tag);
                    produced = 1'b1;
                    cur_tag = 8'd0;
                    stored = 0;
                end
            end
        end
        if (fe) begin
            // frame ended with a command still collecting payload
            if (!produced && remaining != 3'd0) begin
                r = '0;
                r.status = ST_TRUNCATED;
                r.cmd_tag = cur_tag;
                produced = 1'b1;
            end
            cur_tag = 8'd0;
            remaining = 3'd0;
            stored = 0;
            skip_frame = 1'b0;
        end
        if (produced) begin
            decoded_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            v11_en = 1'b0;
            class_b_en = 1'b0;
            cur_tag = 8'd0;
            remaining = 3'd0;
            stored = 0;
            skip_frame = 1'b0;
            decoded_q.delete();
            o_fail_count = 0;
        end else begin
            // result side first: a result never belongs to a byte of the same edge
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, i_result);
                    o_fail_count++;
                end else begin
                    oldest = decoded_q.pop_front();
                    if (i_result !== oldest) begin
                        $display("%0t: tag %0d result mismatch: expected %h, actual %h",
                                 $time, oldest.cmd_tag, oldest, i_result);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_V11) begin
                    v11_en = i_cfg_data;
                end else begin
                    class_b_en = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parse_byte(i_rx_byte, i_frame_end);
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

### tb/tb.sv
module tb
    import ldmc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CMDS       = 18;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic        i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        i_frame_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [7:0]  o_cmd_tag;
    logic [7:0]  o_byte_a;
    logic [7:0]  o_byte_b;
    logic [15:0] o_word_field;
    logic [3:0]  o_nibble_high;
    logic [3:0]  o_nibble_low;
    logic [2:0]  o_tri_a;
    logic [2:0]  o_tri_b;
    logic [2:0]  o_tri_c;
    logic [30:0] o_freq_hz;
    logic [31:0] o_time_seconds;

    t_result     dut_result;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_req;
    logic        hold_served;
    int          hold_left;
    int          idle_cycles;
    logic [7:0]  cmd_tags [NUM_CMDS];
    int          cmd_lens [NUM_CMDS];

    assign dut_result = {o_status, o_cmd_tag, o_byte_a, o_byte_b, o_word_field,
                         o_nibble_high, o_nibble_low, o_tri_a, o_tri_b, o_tri_c,
                         o_freq_hz, o_time_seconds};

    lorawan_downlink_mac_command_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_frame_end    (i_frame_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_cmd_tag      (o_cmd_tag),
        .o_byte_a       (o_byte_a),
        .o_byte_b       (o_byte_b),
        .o_word_field   (o_word_field),
        .o_nibble_high  (o_nibble_high),
        .o_nibble_low   (o_nibble_low),
        .o_tri_a        (o_tri_a),
        .o_tri_b        (o_tri_b),
        .o_tri_c        (o_tri_c),
        .o_freq_hz      (o_freq_hz),
        .o_time_seconds (o_time_seconds)
    );

    mac_cmd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .i_frame_end  (i_frame_end),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_result     (dut_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result consumer: random stalls, plus one long hold-off when requested
    initial begin
        i_out_stall = 1'b0;
        hold_served = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    function automatic logic [7:0] payload_byte();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic fe);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        i_frame_end <= fe;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // mostly well-formed frames; some end mid-command, some carry a stray tag
    task automatic send_frame(output int counted);
        logic [7:0] bytes_q[$];
        int         n_cmds;
        int         pick;
        int         keep;
        logic [7:0] stray;
        n_cmds = $urandom_range(1, 4);
        for (int c = 0; c < n_cmds; c++) begin
            pick = $urandom_range(0, NUM_CMDS - 1);
            keep = cmd_lens[pick];
            if (c == n_cmds - 1 && keep > 0 && $urandom_range(0, 99) < 10) begin
                keep = $urandom_range(0, cmd_lens[pick] - 1);
            end
            bytes_q.push_back(cmd_tags[pick]);
            repeat (keep) bytes_q.push_back(payload_byte());
        end
        counted = bytes_q.size();
        if ($urandom_range(0, 99) < 8) begin
            stray = $urandom_range(0, 1) ? 8'($urandom_range(0, 24))
                                         : 8'($urandom_range(0, 255));
            bytes_q.push_back(stray);
            counted++;
            repeat ($urandom_range(0, 2)) bytes_q.push_back(payload_byte());
        end
        for (int k = 0; k < bytes_q.size(); k++) begin
            send_byte(bytes_q[k], k == bytes_q.size() - 1);
        end
    endtask

    task automatic run_frames(input int target);
        int done;
        int n;
        done = 0;
        while (done < target) begin
            send_frame(n);
            done += n;
        end
    endtask

    // stop offering bytes and let every outstanding result drain
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic v11, input logic class_b);
        for (int k = 0; k < 2; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (k == 0) ? CFG_V11 : CFG_CLASS_B;
            i_cfg_data <= (k == 0) ? v11 : class_b;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_V11;
        i_cfg_data = 1'b0;
        i_in_valid = 1'b0;
        i_rx_byte = 8'd0;
        i_frame_end = 1'b0;
        hold_req = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 57;
        cmd_tags = '{TAG_LINK_CHECK, TAG_LINK_ADR, TAG_DUTY_CYCLE, TAG_RX_PARAM,
                     TAG_DEV_STATUS, TAG_NEW_CHANNEL, TAG_RX_TIMING, TAG_TX_PARAM,
                     TAG_DL_CHANNEL, TAG_RESET_CONF, TAG_ADR_PARAM, TAG_DEVICE_TIME,
                     TAG_FORCE_REJOIN, TAG_REJOIN_PARAM, TAG_PING_SLOT_INFO,
                     TAG_PING_SLOT_CH, TAG_BEACON_TIMING, TAG_BEACON_FREQ};
        cmd_lens = '{2, 4, 1, 4, 0, 5, 1, 1, 4, 1, 1, 5, 2, 1, 0, 4, 3, 3};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: both optional tag groups still disabled from reset
        send_byte(TAG_DEV_STATUS, 1'b0);
        send_byte(TAG_LINK_CHECK, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(TAG_DEVICE_TIME, 1'b0);
        repeat (5) send_byte(8'hFF, 1'b0);
        send_byte(TAG_RESET_CONF, 1'b0);       // disabled: rest of frame dropped
        send_byte(TAG_RX_PARAM, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(TAG_NEW_CHANNEL, 1'b0);      // cut after one payload byte
        send_byte(8'h12, 1'b1);
        send_byte(TAG_LINK_ADR, 1'b1);         // tag itself ends the frame
        send_byte(8'hFF, 1'b1);                // unknown tag on the last byte
        send_byte(8'h00, 1'b0);
        send_byte(TAG_PING_SLOT_INFO, 1'b1);
        send_byte(TAG_PING_SLOT_INFO, 1'b1);
        send_byte(TAG_DEV_STATUS, 1'b1);
        drain();

        configure(1'b1, 1'b1);
        run_frames(510);
        drain();

        send_idle_pct = 57;
        recv_idle_pct = 18;
        configure(1'b0, 1'b1);
        run_frames(510);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(1'b1, 1'b0);
        hold_req = 1'b1;
        run_frames(510);
        drain();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
